@@ sv/alarm_input_qualifier_unit_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef ALARM_INPUT_QUALIFIER_UNIT_DEFINES_SVH
`define ALARM_INPUT_QUALIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define AIQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aiq: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define AIQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aiq: next-cycle check failed");

`endif

@@ sv/aiq_pkg.sv @@
`default_nettype none

package aiq_pkg;

  // Fixed field widths
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned HoldW     = 8;
  localparam int unsigned MaskW     = 5;
  localparam int unsigned SrcW      = 3;

  // Default debounce counter width
  localparam int unsigned CountWidthDef = 8;

  // Register values after reset
  localparam logic [LimitW-1:0] KeyLimitRst      = 8'd3;
  localparam logic [LimitW-1:0] PowerLimitRst    = 8'd100;
  localparam logic [LimitW-1:0] SwitchLimitRst   = 8'd20;
  localparam logic [LimitW-1:0] SensorLimitRst   = 8'd5;
  localparam logic [HoldW-1:0]  MotionHoldoffRst = 8'd20;
  localparam logic [HoldW-1:0]  KnockHoldoffRst  = 8'd50;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARMED          = 3'd0,
    CFG_KEY_LIMIT      = 3'd1,
    CFG_POWER_LIMIT    = 3'd2,
    CFG_SWITCH_LIMIT   = 3'd3,
    CFG_SENSOR_LIMIT   = 3'd4,
    CFG_MOTION_HOLDOFF = 3'd5,
    CFG_KNOCK_HOLDOFF  = 3'd6
  } cfg_idx_e;

  // Message source codes
  typedef enum logic [SrcW-1:0] {
    SRC_NONE   = 3'd0,
    SRC_KEY    = 3'd1,
    SRC_POWER  = 3'd2,
    SRC_SWITCH = 3'd3,
    SRC_MOTION = 3'd4,
    SRC_KNOCK  = 3'd5
  } src_e;

  // Bit positions in the fired mask
  localparam int unsigned BitKey    = 0;
  localparam int unsigned BitPower  = 1;
  localparam int unsigned BitSwitch = 2;
  localparam int unsigned BitMotion = 3;
  localparam int unsigned BitKnock  = 4;

  typedef struct packed {
    logic              armed;
    logic [LimitW-1:0] key_limit;
    logic [LimitW-1:0] power_limit;
    logic [LimitW-1:0] switch_limit;
    logic [LimitW-1:0] sensor_limit;
    logic [HoldW-1:0]  motion_holdoff;
    logic [HoldW-1:0]  knock_holdoff;
  } cfg_t;

  typedef struct packed {
    logic frame_start;
    logic key_level;
    logic power_level;
    logic switch_level;
    logic motion_level;
    logic knock_level;
  } sample_t;

  typedef struct packed {
    logic [MaskW-1:0] fired_mask;
    logic             alert;
    src_e             message_source;
  } result_t;

endpackage

`default_nettype wire

@@ sv/aiq_cfg_regs.sv @@
`default_nettype none

module aiq_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [aiq_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [aiq_pkg::CfgDataW-1:0] cfg_data_i,
  output aiq_pkg::cfg_t               cfg_o
);
  import aiq_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the register index and update the addressed field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ARMED:          cfg_d.armed          = cfg_data_i[0];
        CFG_KEY_LIMIT:      cfg_d.key_limit      = cfg_data_i;
        CFG_POWER_LIMIT:    cfg_d.power_limit    = cfg_data_i;
        CFG_SWITCH_LIMIT:   cfg_d.switch_limit   = cfg_data_i;
        CFG_SENSOR_LIMIT:   cfg_d.sensor_limit   = cfg_data_i;
        CFG_MOTION_HOLDOFF: cfg_d.motion_holdoff = cfg_data_i;
        CFG_KNOCK_HOLDOFF:  cfg_d.knock_holdoff  = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.armed          <= 1'b0;
      cfg_q.key_limit      <= KeyLimitRst;
      cfg_q.power_limit    <= PowerLimitRst;
      cfg_q.switch_limit   <= SwitchLimitRst;
      cfg_q.sensor_limit   <= SensorLimitRst;
      cfg_q.motion_holdoff <= MotionHoldoffRst;
      cfg_q.knock_holdoff  <= KnockHoldoffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/aiq_qualify.sv @@
`default_nettype none

module aiq_qualify #(
  parameter int unsigned COUNT_WIDTH = aiq_pkg::CountWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  aiq_pkg::sample_t smp_i,
  input  aiq_pkg::cfg_t    cfg_i,
  output aiq_pkg::result_t res_o
);
  import aiq_pkg::*;

  // Compare width covers both the counter and the limit
  localparam int unsigned CmpW = (COUNT_WIDTH > LimitW) ? COUNT_WIDTH : LimitW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [COUNT_WIDTH-1:0] key_count_q,    key_count_d;
  logic [COUNT_WIDTH-1:0] power_count_q,  power_count_d;
  logic [COUNT_WIDTH-1:0] switch_count_q, switch_count_d;
  logic [COUNT_WIDTH-1:0] motion_count_q, motion_count_d;
  logic [COUNT_WIDTH-1:0] knock_count_q,  knock_count_d;
  logic                   power_ready_q,  power_ready_d;
  logic                   switch_ready_q, switch_ready_d;
  logic                   motion_ready_q, motion_ready_d;
  logic                   knock_ready_q,  knock_ready_d;
  logic [HoldW-1:0]       motion_wait_q,  motion_wait_d;
  logic [HoldW-1:0]       knock_wait_q,   knock_wait_d;
  logic [MaskW-1:0]       mask;

  // Judge one sample against the debounce state
  always_comb begin
    logic [HoldW-1:0]       mw;
    logic [HoldW-1:0]       kw;
    logic [COUNT_WIDTH-1:0] cnt;

    key_count_d    = key_count_q;
    power_count_d  = power_count_q;
    switch_count_d = switch_count_q;
    motion_count_d = motion_count_q;
    knock_count_d  = knock_count_q;
    power_ready_d  = power_ready_q;
    switch_ready_d = switch_ready_q;
    motion_ready_d = motion_ready_q;
    knock_ready_d  = knock_ready_q;
    mask           = '0;
    cnt            = '0;

    // Advance the holdoffs on a frame start
    mw = motion_wait_q;
    kw = knock_wait_q;
    if (smp_i.frame_start) begin
      if (mw != '0) mw = mw - 1'b1;
      if (kw != '0) kw = kw - 1'b1;
    end

    // Key: fires on every run of limit+1 low samples
    if (!smp_i.key_level) begin
      cnt = (key_count_q == CountMax) ? key_count_q : key_count_q + 1'b1;
      if (CmpW'(cnt) > CmpW'(cfg_i.key_limit)) begin
        mask[BitKey] = 1'b1;
        cnt          = '0;
      end
      key_count_d = cnt;
    end else begin
      key_count_d = '0;
    end

    // Power loss: fires once, re-arms on a high sample
    if (!smp_i.power_level) begin
      if (power_ready_q) begin
        cnt = (power_count_q == CountMax) ? power_count_q : power_count_q + 1'b1;
        if (CmpW'(cnt) > CmpW'(cfg_i.power_limit)) begin
          mask[BitPower] = 1'b1;
          cnt            = '0;
          power_ready_d  = 1'b0;
        end
        power_count_d = cnt;
      end
    end else begin
      power_ready_d = 1'b1;
      power_count_d = '0;
    end

    // Switch on: fires once, re-arms on a low sample
    if (smp_i.switch_level) begin
      if (switch_ready_q) begin
        cnt = (switch_count_q == CountMax) ? switch_count_q : switch_count_q + 1'b1;
        if (CmpW'(cnt) > CmpW'(cfg_i.switch_limit)) begin
          mask[BitSwitch] = cfg_i.armed;
          cnt             = '0;
          switch_ready_d  = 1'b0;
        end
        switch_count_d = cnt;
      end
    end else begin
      switch_ready_d = 1'b1;
      switch_count_d = '0;
    end

    // Motion and knock: judged only while the switch is off
    if (!smp_i.switch_level) begin
      if (smp_i.motion_level) begin
        if (motion_ready_q && mw == '0) begin
          cnt = (motion_count_q == CountMax) ? motion_count_q : motion_count_q + 1'b1;
          if (CmpW'(cnt) > CmpW'(cfg_i.sensor_limit)) begin
            mask[BitMotion] = cfg_i.armed;
            cnt             = '0;
            mw              = cfg_i.motion_holdoff;
            motion_ready_d  = 1'b0;
          end
          motion_count_d = cnt;
        end
      end else begin
        motion_ready_d = 1'b1;
        motion_count_d = '0;
      end

      if (!smp_i.knock_level) begin
        if (knock_ready_q && kw == '0) begin
          cnt = (knock_count_q == CountMax) ? knock_count_q : knock_count_q + 1'b1;
          if (CmpW'(cnt) > CmpW'(cfg_i.sensor_limit)) begin
            mask[BitKnock] = cfg_i.armed;
            cnt            = '0;
            kw             = cfg_i.knock_holdoff;
            knock_ready_d  = 1'b0;
          end
          knock_count_d = cnt;
        end
      end else begin
        knock_ready_d = 1'b1;
        knock_count_d = '0;
      end
    end

    motion_wait_d = mw;
    knock_wait_d  = kw;
  end

  // Pick the highest alerting channel
  always_comb begin
    res_o.fired_mask = mask;
    res_o.alert      = |mask;
    if (mask[BitKnock])       res_o.message_source = SRC_KNOCK;
    else if (mask[BitMotion]) res_o.message_source = SRC_MOTION;
    else if (mask[BitSwitch]) res_o.message_source = SRC_SWITCH;
    else if (mask[BitPower])  res_o.message_source = SRC_POWER;
    else if (mask[BitKey])    res_o.message_source = SRC_KEY;
    else                      res_o.message_source = SRC_NONE;
  end

  // Advance the channel state once per judged sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q    <= '0;
      power_count_q  <= '0;
      switch_count_q <= '0;
      motion_count_q <= '0;
      knock_count_q  <= '0;
      power_ready_q  <= 1'b0;
      switch_ready_q <= 1'b0;
      motion_ready_q <= 1'b0;
      knock_ready_q  <= 1'b0;
      motion_wait_q  <= '0;
      knock_wait_q   <= '0;
    end else if (step_i) begin
      key_count_q    <= key_count_d;
      power_count_q  <= power_count_d;
      switch_count_q <= switch_count_d;
      motion_count_q <= motion_count_d;
      knock_count_q  <= knock_count_d;
      power_ready_q  <= power_ready_d;
      switch_ready_q <= switch_ready_d;
      motion_ready_q <= motion_ready_d;
      knock_ready_q  <= knock_ready_d;
      motion_wait_q  <= motion_wait_d;
      knock_wait_q   <= knock_wait_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/alarm_input_qualifier_unit.sv @@
// Path: a request is held in the input register and its result in the result register.
// Throughput: one request per cycle unless a stalled result holds the input register;
// the input register and the result register each hold one item, and the channel state
// advances once per judged sample.
// Reset: asynchronous, active low; debounce state cleared, registers to defaults.
`default_nettype none

module alarm_input_qualifier_unit #(
  parameter int unsigned COUNT_WIDTH = aiq_pkg::CountWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aiq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aiq_pkg::CfgDataW-1:0] cfg_data_i,
  // Sample requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         frame_start_i,
  input  logic                         key_level_i,
  input  logic                         power_level_i,
  input  logic                         switch_level_i,
  input  logic                         motion_level_i,
  input  logic                         knock_level_i,
  // Results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [aiq_pkg::MaskW-1:0]    fired_mask_o,
  output logic                         alert_o,
  output logic [aiq_pkg::SrcW-1:0]     message_source_o
);
  import aiq_pkg::*;

  cfg_t    cfg;
  sample_t smp_q;
  result_t res;
  result_t res_q;
  logic    in_vld_q, in_vld_d;
  logic    out_vld_q, out_vld_d;
  logic    in_accept;
  logic    advance;

  // Configuration is taken in any cycle
  assign cfg_ready_o = 1'b1;

  aiq_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held sample on when the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept)    in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;

    out_vld_d = out_vld_q;
    if (advance)                       out_vld_d = 1'b1;
    else if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
  end

  aiq_qualify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_qualify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .smp_i  (smp_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the sample and the result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q.frame_start  <= frame_start_i;
      smp_q.key_level    <= key_level_i;
      smp_q.power_level  <= power_level_i;
      smp_q.switch_level <= switch_level_i;
      smp_q.motion_level <= motion_level_i;
      smp_q.knock_level  <= knock_level_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign fired_mask_o     = res_q.fired_mask;
  assign alert_o          = res_q.alert;
  assign message_source_o = res_q.message_source;

endmodule

`default_nettype wire

@@ sv/aiq_checker.sv @@
`default_nettype none
`include "alarm_input_qualifier_unit_defines.svh"

module aiq_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [aiq_pkg::MaskW-1:0] fired_mask_o,
  input wire logic                      alert_o,
  input wire logic [aiq_pkg::SrcW-1:0]  message_source_o
);
  import aiq_pkg::*;

  // A stalled result holds
  `AIQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(fired_mask_o) && $stable(message_source_o))

  // The alert flag follows the mask
  `AIQ_ASSERT_SAME(a_alert_mask, out_valid_o, alert_o == (fired_mask_o != '0))

  // Knock outranks every other source
  `AIQ_ASSERT_SAME(a_knock_wins, out_valid_o && fired_mask_o[BitKnock], message_source_o == SRC_KNOCK)

  // No alert means no source
  `AIQ_ASSERT_SAME(a_quiet_src, out_valid_o && fired_mask_o == '0, message_source_o == SRC_NONE)

  // Input stalls only behind a blocked result
  `AIQ_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind alarm_input_qualifier_unit aiq_checker u_aiq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .fired_mask_o     (fired_mask_o),
  .alert_o          (alert_o),
  .message_source_o (message_source_o)
);

`default_nettype wire
